// ===== rtl/bamr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus address map RAM package
// Access codes, status codes, address map constants and word layouts shared
// by the bus access port.
// ----------------------------------------------------------------------------
package bamr_pkg;

  // Access modes
  localparam logic [1:0] MODE_READ_BYTE  = 2'd0;
  localparam logic [1:0] MODE_READ_WORD  = 2'd1;
  localparam logic [1:0] MODE_WRITE_BYTE = 2'd2;
  localparam logic [1:0] MODE_WRITE_WORD = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_BOUNDARY = 2'd2;

  // Address map: top 4 KB of virtual space lands in the 18-bit I/O page
  localparam int unsigned PHYS_W       = 18;
  localparam int unsigned WIDX_W       = PHYS_W - 1;
  localparam logic [15:0] IO_PAGE_VIRT = 16'o170000;
  localparam logic [17:0] IO_PAGE_BASE = 18'o770000;

  // Configuration register width and reset value
  localparam int unsigned CFG_W           = 18;
  localparam logic [17:0] RAM_WORDS_RESET = 18'd131072;

  // Input word layout, last field in the low bits
  typedef struct packed {
    logic [15:0] write_data;
    logic [15:0] address;
    logic [1:0]  mode;
  } in_word_t;

  // Result word layout, last field in the low bits
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_data;
  } out_word_t;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

endpackage

// ===== rtl/bus_address_map_ram_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus address map RAM core
// Byte/word bus access port in front of a cleared 16-bit core memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bus access per word (mode, address, write data);
//   m_axis returns one result per access (read data, status).
//   cfg_we/cfg_data write the number of core words present; write it only
//   while no access is in flight.
// Path: an access is registered in stage 1, and its result is registered in
//   stage 2 and shown on m_axis from there.
// Throughput: one access per cycle while m_axis_tready is high; the core memory has one write port and
//   one registered read port, and byte writes use lane enables, so no
//   read-modify-write cycle is needed.
// Reset: the memory is swept to zero one word per cycle, all RAM_WORDS words
//   (131072 at the default); s_axis_tready stays low meanwhile.
//   Configuration writes are taken during the sweep.
// Stall: when m_axis_tready is low the result and the access behind it
//   hold, and s_axis_tready drops once both stages are full.
// ----------------------------------------------------------------------------
module bus_address_map_ram_core #(
  parameter int unsigned RAM_WORDS = 131072
) (
  input  logic        clk,
  input  logic        rst,
  // cfg_data: ram_words[17:0]
  input  logic        cfg_we,
  input  logic [17:0] cfg_data,
  // s_axis_tdata: mode[1:0], address[17:2], write_data[33:18], zero[39:34]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // m_axis_tdata: read_data[15:0], status[17:16], zero[23:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam logic [17:0] RamWordsW = 18'(RAM_WORDS);
  localparam logic [AW-1:0] ClrLast = AW'(RAM_WORDS - 1);

  // Configuration register
  logic [17:0] ram_words;
  logic [17:0] words_eff;

  // Clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Stage 1: registered access
  logic                 s1_valid;
  bamr_pkg::in_word_t   s1;
  logic                 advance;

  // Stage 1 decode
  logic                        s1_io;
  logic [17:0]                 s1_phys;
  logic [bamr_pkg::WIDX_W-1:0] s1_widx;
  logic                        s1_odd;
  logic                        s1_is_word;
  logic                        s1_is_write;
  logic [1:0]                  s1_status;

  // Memory ports
  logic [7:0]    mem_lo [RAM_WORDS];
  logic [7:0]    mem_hi [RAM_WORDS];
  logic          acc_we;
  logic          we_lo;
  logic          we_hi;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata_lo;
  logic [7:0]    wdata_hi;
  logic          rd_en;
  logic [7:0]    rd_lo;
  logic [7:0]    rd_hi;

  // Stage 2: result
  logic       s2_valid;
  logic [1:0] s2_status;
  logic       s2_read;
  logic       s2_word;
  logic       s2_odd;
  bamr_pkg::out_word_t out_word;

  // Hold the configured word count
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_words <= bamr_pkg::RAM_WORDS_RESET;
    end else if (cfg_we) begin
      ram_words <= cfg_data;
    end
  end

  // Saturate the word count at the built memory size
  assign words_eff = (ram_words > RamWordsW) ? RamWordsW : ram_words;

  // Sweep the memory to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ClrLast) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Pipeline flow control
  assign advance       = !s2_valid || m_axis_tready;
  assign s_axis_tready = !clearing && (!s1_valid || advance);

  // Register the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1 <= bamr_pkg::in_word_t'(s_axis_tdata[$bits(bamr_pkg::in_word_t)-1:0]);
    end
  end

  // Map the virtual address and check for aborts
  always_comb begin
    s1_io       = (s1.address >= bamr_pkg::IO_PAGE_VIRT);
    s1_phys     = s1_io ? (bamr_pkg::IO_PAGE_BASE | {2'b00, s1.address})
                        : {2'b00, s1.address};
    s1_widx     = s1_phys[bamr_pkg::PHYS_W-1:1];
    s1_odd      = s1_phys[0];
    s1_is_word  = (s1.mode == bamr_pkg::MODE_READ_WORD) ||
                  (s1.mode == bamr_pkg::MODE_WRITE_WORD);
    s1_is_write = (s1.mode == bamr_pkg::MODE_WRITE_BYTE) ||
                  (s1.mode == bamr_pkg::MODE_WRITE_WORD);
    priority if ({1'b0, s1_widx} >= words_eff) begin
      s1_status = bamr_pkg::STATUS_TIMEOUT;
    end else if (s1_is_word && s1_odd) begin
      s1_status = bamr_pkg::STATUS_BOUNDARY;
    end else begin
      s1_status = bamr_pkg::STATUS_OK;
    end
  end

  // Drive the write port: sweep first, else lane-enabled access writes
  always_comb begin
    acc_we = s1_valid && advance && s1_is_write &&
             (s1_status == bamr_pkg::STATUS_OK);
    if (clearing) begin
      we_lo    = 1'b1;
      we_hi    = 1'b1;
      waddr    = clr_addr;
      wdata_lo = '0;
      wdata_hi = '0;
    end else begin
      we_lo    = acc_we && (s1_is_word || !s1_odd);
      we_hi    = acc_we && (s1_is_word || s1_odd);
      waddr    = s1_widx[AW-1:0];
      wdata_lo = s1.write_data[7:0];
      wdata_hi = s1_is_word ? s1.write_data[15:8] : s1.write_data[7:0];
    end
  end

  assign rd_en = s1_valid && advance;

  // Core memory, one byte array per lane
  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem_lo[waddr] <= wdata_lo;
    end
    if (rd_en) begin
      rd_lo <= mem_lo[s1_widx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_hi) begin
      mem_hi[waddr] <= wdata_hi;
    end
    if (rd_en) begin
      rd_hi <= mem_hi[s1_widx[AW-1:0]];
    end
  end

  // Advance the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_status <= s1_status;
      s2_read   <= !s1_is_write;
      s2_word   <= s1_is_word;
      s2_odd    <= s1_odd;
    end
  end

  // Select the read lane; writes and aborts return zero
  always_comb begin
    out_word.status = s2_status;
    if (!s2_read || (s2_status != bamr_pkg::STATUS_OK)) begin
      out_word.read_data = '0;
    end else if (s2_word) begin
      out_word.read_data = {rd_hi, rd_lo};
    end else if (s2_odd) begin
      out_word.read_data = {8'h00, rd_hi};
    end else begin
      out_word.read_data = {8'h00, rd_lo};
    end
  end

  assign m_axis_tvalid = s2_valid;
  assign m_axis_tdata  = {{(bamr_pkg::OUT_TDATA_W - $bits(bamr_pkg::out_word_t)){1'b0}},
                          out_word};

  // No access is taken while the sweep runs
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("access accepted during memory clear");

  // A stalled stage-one access is not dropped
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("stage one access lost under stall");

  // Only accesses that pass both checks write the memory
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    !clearing && (we_lo || we_hi) |-> s1_status == bamr_pkg::STATUS_OK && s1_is_write)
    else $error("memory write from aborted or read access");

  // Aborted results carry zero data
  a_abort_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (s2_status != bamr_pkg::STATUS_OK) |-> m_axis_tdata[15:0] == 16'h0000)
    else $error("aborted access returned data");

endmodule
